// ----- hw/rtl/beacon_rssi_line_ranger_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the beacon RSSI line ranger.
// Both macros expect signals named clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef BEACON_RSSI_LINE_RANGER_MACROS_SVH
`define BEACON_RSSI_LINE_RANGER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/brl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_pkg
// Shared constants and lookup functions of the beacon RSSI line ranger.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int BYTE_W = 8;
  localparam int RSSI_W = 7;
  localparam int DIST_W = 6;
  localparam int STEP_W = 4;
  localparam int OFFS_W = 6;

  localparam logic [BYTE_W-1:0] EOL_RESET = 8'd13;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
  localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
  localparam logic [BYTE_W-1:0] CH_S      = 8'h53;
  localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
  localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
  localparam logic [BYTE_W-1:0] CH_1      = 8'h31;
  localparam logic [BYTE_W-1:0] CH_2      = 8'h32;
  localparam logic [BYTE_W-1:0] CH_3      = 8'h33;

  localparam logic [RSSI_W-1:0] RSSI_MAX = 7'd99;

  // Scan steps: one line store read each.
  localparam logic [STEP_W-1:0] K_M   = 4'd0;
  localparam logic [STEP_W-1:0] K_A   = 4'd1;
  localparam logic [STEP_W-1:0] K_C   = 4'd2;
  localparam logic [STEP_W-1:0] K_SEL = 4'd3;
  localparam logic [STEP_W-1:0] K_S   = 4'd4;
  localparam logic [STEP_W-1:0] K_P   = 4'd5;
  localparam logic [STEP_W-1:0] K_3   = 4'd6;
  localparam logic [STEP_W-1:0] K_D1  = 4'd7;
  localparam logic [STEP_W-1:0] K_D2  = 4'd8;

  function automatic logic [OFFS_W-1:0] step_offset(input logic [STEP_W-1:0] k);
    logic [OFFS_W-1:0] o;
    case (k)
      K_M:     o = 6'd0;
      K_A:     o = 6'd1;
      K_C:     o = 6'd2;
      K_SEL:   o = 6'd20;
      K_S:     o = 6'd32;
      K_P:     o = 6'd33;
      K_3:     o = 6'd48;
      K_D1:    o = 6'd28;
      K_D2:    o = 6'd29;
      default: o = 6'd0;
    endcase
    return o;
  endfunction

  // floor(10^((avg-49)/31.6)) for avg in 0..99.
  function automatic logic [DIST_W-1:0] dist_lookup(input logic [RSSI_W-1:0] avg);
    logic [DIST_W-1:0] d;
    case (avg)
      7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd58: d = 6'd1;
      7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64: d = 6'd2;
      7'd65, 7'd66, 7'd67, 7'd68: d = 6'd3;
      7'd69, 7'd70, 7'd71: d = 6'd4;
      7'd72, 7'd73: d = 6'd5;
      7'd74, 7'd75: d = 6'd6;
      7'd76, 7'd77: d = 6'd7;
      7'd78, 7'd79: d = 6'd8;
      7'd80: d = 6'd9;
      7'd81: d = 6'd10;
      7'd82, 7'd83: d = 6'd11;
      7'd84: d = 6'd12;
      7'd85: d = 6'd13;
      7'd86: d = 6'd14;
      7'd87: d = 6'd15;
      7'd88: d = 6'd17;
      7'd89: d = 6'd18;
      7'd90: d = 6'd19;
      7'd91: d = 6'd21;
      7'd92: d = 6'd22;
      7'd93: d = 6'd24;
      7'd94: d = 6'd26;
      7'd95: d = 6'd28;
      7'd96: d = 6'd30;
      7'd97: d = 6'd33;
      7'd98: d = 6'd35;
      7'd99: d = 6'd38;
      default: d = 6'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- hw/rtl/beacon_rssi_line_ranger.sv -----
`timescale 1ns / 1ps
// A data byte is written to the line store. A line end byte starts a scan of
// every line position through the steps of a "MAC" report, a window update for
// each hit, an averaging of each of the three window sums and the result output.
// All scan reads go through the single read port of the line store. One byte in
// flight at a time. After reset the line store and windows are zeroed by a
// clearing pass; no byte is taken before it ends.
// ----------------------------------------------------------------------------
// beacon_rssi_line_ranger
// Collects serial bytes into a line store, scans each line for beacon reports
// and keeps per-beacon RSSI windows with running sums for distance reports.
// ----------------------------------------------------------------------------
module beacon_rssi_line_ranger
  import brl_pkg::*;
#(
  parameter int LINE_DEPTH = 512,
  parameter int WINDOW_LEN = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_report_ready,
  output logic [2:0]        out_beacon1_status,
  output logic [DIST_W-1:0] out_beacon1_distance,
  output logic [2:0]        out_beacon2_status,
  output logic [DIST_W-1:0] out_beacon2_distance,
  output logic [2:0]        out_beacon3_status,
  output logic [DIST_W-1:0] out_beacon3_distance
);

  localparam int AW    = $clog2(LINE_DEPTH);
  localparam int WD    = 3 * WINDOW_LEN;
  localparam int WMAW  = $clog2(WD);
  localparam int WPW   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SW    = $clog2(99 * WINDOW_LEN + 1);
  localparam int CLRN  = (LINE_DEPTH > WD) ? LINE_DEPTH : WD;
  localparam int CW    = $clog2(CLRN);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_EV, ST_WRD, ST_WWR, ST_DIV_GO, ST_DIV_WAIT, ST_FIN
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      clr_r;
  logic [BYTE_W-1:0]  eol_r;
  logic [AW:0]        len_r;
  logic [AW-1:0]      z_r;
  logic [AW-1:0]      scan_last_r;
  logic [STEP_W-1:0]  k_r;
  logic               oob_r;
  logic [1:0]         bsel_r;
  logic               tag_r;
  logic [BYTE_W-1:0]  d1_r;
  logic [RSSI_W-1:0]  rssi_r;
  logic [WPW-1:0]     wpos_r [3];
  logic [SW-1:0]      sum_r  [3];
  logic [2:0]         stat_r [3];
  logic [DIST_W-1:0]  dist_r [3];
  logic [1:0]         dcnt_r;
  logic               wrap_r;
  logic               ready_r;
  logic               out_valid_r;
  logic               out_ready_r;
  logic [2:0]         out_stat_r [3];
  logic [DIST_W-1:0]  out_dist_r [3];

  logic               in_xfer;
  logic               is_eol;
  logic [AW-1:0]      wr_pos;
  logic [AW:0]        rd_p;
  logic [BYTE_W-1:0]  byte_v;
  logic               lm_we;
  logic [AW-1:0]      lm_waddr;
  logic [BYTE_W-1:0]  lm_wdata;
  logic [BYTE_W-1:0]  lm_rdata;
  logic               wm_we;
  logic [WMAW-1:0]    wm_waddr;
  logic [WMAW-1:0]    win_addr;
  logic [RSSI_W-1:0]  wm_wdata;
  logic [RSSI_W-1:0]  wm_rdata;
  logic               div_start;
  logic               div_done;
  logic [RSSI_W-1:0]  div_q;
  logic signed [12:0] hi_v;
  logic signed [12:0] rssi_v;
  logic [RSSI_W-1:0]  rssi_c;
  logic               last_z;
  logic               ev_miss;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign is_eol   = (in_rx_byte == eol_r);
  assign wr_pos   = (len_r >= (AW + 1)'(LINE_DEPTH - 1)) ? AW'(LINE_DEPTH - 1)
                                                         : len_r[AW-1:0];
  assign rd_p     = {1'b0, z_r} + (AW + 1)'(step_offset(k_r));
  assign byte_v   = oob_r ? '0 : lm_rdata;
  assign win_addr = WMAW'(bsel_r) * WMAW'(WINDOW_LEN) + WMAW'(wpos_r[bsel_r]);
  assign last_z   = (z_r == scan_last_r);
  assign div_start = (state_r == ST_DIV_GO);

  // RSSI from two decimal digits; non-digits still count by their code.
  always_comb begin
    hi_v   = $signed({5'b0, d1_r}) - 13'sd48;
    rssi_v = (hi_v <<< 3) + (hi_v <<< 1) + $signed({5'b0, byte_v}) - 13'sd48;
    if (rssi_v < 13'sd0) begin
      rssi_c = '0;
    end else if (rssi_v > 13'sd99) begin
      rssi_c = RSSI_MAX;
    end else begin
      rssi_c = rssi_v[RSSI_W-1:0];
    end
  end

  // A miss ends the work at the current scan position.
  always_comb begin
    case (k_r)
      K_M:     ev_miss = (byte_v != CH_M);
      K_A:     ev_miss = (byte_v != CH_A);
      K_C:     ev_miss = (byte_v != CH_C);
      K_SEL:   ev_miss = (byte_v != CH_1) && (byte_v != CH_2) && (byte_v != CH_3);
      default: ev_miss = 1'b0;
    endcase
  end

  always_comb begin
    lm_we    = 1'b0;
    lm_waddr = wr_pos;
    lm_wdata = is_eol ? '0 : in_rx_byte;
    wm_we    = 1'b0;
    wm_waddr = win_addr;
    wm_wdata = rssi_r;
    case (state_r)
      ST_CLEAR: begin
        lm_we    = {1'b0, clr_r} < (CW + 1)'(LINE_DEPTH);
        lm_waddr = clr_r[AW-1:0];
        lm_wdata = '0;
        wm_we    = {1'b0, clr_r} < (CW + 1)'(WD);
        wm_waddr = clr_r[WMAW-1:0];
        wm_wdata = '0;
      end
      ST_IDLE: lm_we = in_xfer;
      ST_WWR:  wm_we = 1'b1;
      default: ;
    endcase
  end

  brl_ram #(.DEPTH(LINE_DEPTH), .WIDTH(BYTE_W)) u_line_mem (
    .clk   (clk),
    .we    (lm_we),
    .waddr (lm_waddr),
    .wdata (lm_wdata),
    .raddr (rd_p[AW-1:0]),
    .rdata (lm_rdata)
  );

  brl_ram #(.DEPTH(WD), .WIDTH(RSSI_W)) u_win_mem (
    .clk   (clk),
    .we    (wm_we),
    .waddr (wm_waddr),
    .wdata (wm_wdata),
    .raddr (win_addr),
    .rdata (wm_rdata)
  );

  brl_avg_div #(.SW(SW), .DIVISOR(WINDOW_LEN)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[dcnt_r]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      eol_r       <= EOL_RESET;
      len_r       <= '0;
      wrap_r      <= 1'b0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      dcnt_r      <= '0;
      for (int b = 0; b < 3; b++) begin
        wpos_r[b] <= '0;
        sum_r[b]  <= '0;
        stat_r[b] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        eol_r <= cfg_wr_data;
      end
      // The result stage reloads the output register itself.
      if (out_valid_r && !out_stall && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CW'(CLRN - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            if (is_eol) begin
              len_r       <= '0;
              scan_last_r <= wr_pos;
              z_r         <= '0;
              k_r         <= K_M;
              if (wrap_r) begin
                ready_r <= 1'b1;
              end
              state_r <= ST_RD;
            end else begin
              len_r <= {1'b0, wr_pos} + 1'b1;
            end
          end
        end
        ST_RD: begin
          oob_r   <= rd_p >= (AW + 1)'(LINE_DEPTH);
          state_r <= ST_EV;
        end
        ST_EV: begin
          if (ev_miss) begin
            k_r <= K_M;
            z_r <= z_r + 1'b1;
            if (last_z) begin
              dcnt_r  <= '0;
              state_r <= ST_DIV_GO;
            end else begin
              state_r <= ST_RD;
            end
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= (k_r == K_D2) ? ST_WRD : ST_RD;
          end
          case (k_r)
            K_SEL: begin
              tag_r <= 1'b1;
              if (byte_v == CH_2) begin
                bsel_r <= 2'd1;
              end else if (byte_v == CH_3) begin
                bsel_r <= 2'd2;
              end else begin
                bsel_r <= 2'd0;
              end
            end
            K_S: tag_r <= tag_r && (byte_v == CH_S);
            K_P: tag_r <= tag_r && (byte_v == CH_P);
            K_3: tag_r <= tag_r && (byte_v == CH_3);
            K_D1: d1_r <= byte_v;
            K_D2: rssi_r <= rssi_c;
            default: ;
          endcase
        end
        ST_WRD: state_r <= ST_WWR;
        ST_WWR: begin
          // Running sum replaces the overwritten entry with the new one.
          sum_r[bsel_r] <= SW'({1'b0, sum_r[bsel_r]} + (SW + 1)'(rssi_r)
                               - (SW + 1)'(wm_rdata));
          if (wpos_r[bsel_r] == WPW'(WINDOW_LEN - 1)) begin
            wpos_r[bsel_r] <= '0;
            stat_r[bsel_r] <= stat_r[bsel_r] | {1'b1, tag_r, 1'b1};
            wrap_r         <= 1'b1;
          end else begin
            wpos_r[bsel_r] <= wpos_r[bsel_r] + 1'b1;
            stat_r[bsel_r] <= stat_r[bsel_r] | {1'b0, tag_r, 1'b1};
          end
          k_r <= K_M;
          z_r <= z_r + 1'b1;
          if (last_z) begin
            dcnt_r  <= '0;
            state_r <= ST_DIV_GO;
          end else begin
            state_r <= ST_RD;
          end
        end
        ST_DIV_GO: state_r <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done) begin
            dist_r[dcnt_r] <= dist_lookup(div_q);
            if (dcnt_r == 2'd2) begin
              state_r <= ST_FIN;
            end else begin
              dcnt_r  <= dcnt_r + 1'b1;
              state_r <= ST_DIV_GO;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_ready_r <= ready_r;
            for (int b = 0; b < 3; b++) begin
              out_stat_r[b] <= stat_r[b];
              out_dist_r[b] <= dist_r[b];
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_report_ready     = out_ready_r;
  assign out_beacon1_status   = out_stat_r[0];
  assign out_beacon1_distance = out_dist_r[0];
  assign out_beacon2_status   = out_stat_r[1];
  assign out_beacon2_distance = out_dist_r[1];
  assign out_beacon3_status   = out_stat_r[2];
  assign out_beacon3_distance = out_dist_r[2];

endmodule

// ----- hw/rtl/brl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_ram
// Single write port, single read port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module brl_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/brl_avg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_avg_div
// Window sum divided by the window length with a reciprocal multiplication;
// the quotient is registered when start is high and clamped to 0..99.
// ----------------------------------------------------------------------------
module brl_avg_div
  import brl_pkg::*;
#(
  parameter int SW      = 11,
  parameter int DIVISOR = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SW-1:0]     dividend,
  output logic              done,
  output logic [RSSI_W-1:0] quotient
);

  // With m = ceil(2^(SW+L)/d) and L = ceil(log2 d), (n*m) >> (SW+L) equals
  // floor(n/d) for every SW-bit n.
  localparam int LW    = $clog2(DIVISOR);
  localparam int SH    = SW + LW;
  localparam int MW    = SW + 2;
  localparam int PW    = SH + SW;
  localparam logic [MW-1:0] RECIP = MW'((2 ** SH + DIVISOR - 1) / DIVISOR);

  logic [PW-1:0] prod;
  logic [SW-1:0] quo_v;
  logic [SW-1:0] quo_r;
  logic          done_r;

  assign prod  = PW'(dividend) * PW'(RECIP);
  assign quo_v = prod[SH +: SW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
      if (start) begin
        quo_r <= quo_v;
      end
    end
  end

  assign done     = done_r;
  assign quotient = (quo_r > SW'(RSSI_MAX)) ? RSSI_MAX : quo_r[RSSI_W-1:0];

endmodule

// ----- hw/rtl/brl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_checker
// Port-level checks of the beacon RSSI line ranger, bound to the top level.
// ----------------------------------------------------------------------------
`include "beacon_rssi_line_ranger_macros.svh"

module brl_checker
  import brl_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_report_ready,
  input logic [2:0]        out_beacon1_status,
  input logic [DIST_W-1:0] out_beacon1_distance,
  input logic [2:0]        out_beacon2_status,
  input logic [DIST_W-1:0] out_beacon2_distance,
  input logic [2:0]        out_beacon3_status,
  input logic [DIST_W-1:0] out_beacon3_distance
);

  logic dist_ok;
  logic seen_ok;
  logic wrap_any;

  assign dist_ok = (out_beacon1_distance <= 6'd38) && (out_beacon2_distance <= 6'd38) &&
                   (out_beacon3_distance <= 6'd38);
  // A tag or wrap flag can only appear on a beacon that has been seen.
  assign seen_ok = (out_beacon1_status[0] || out_beacon1_status[2:1] == 2'b00) &&
                   (out_beacon2_status[0] || out_beacon2_status[2:1] == 2'b00) &&
                   (out_beacon3_status[0] || out_beacon3_status[2:1] == 2'b00);
  assign wrap_any = out_beacon1_status[2] || out_beacon2_status[2] || out_beacon3_status[2];

  `BRL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `BRL_ASSERT_SAME(a_dist_range, out_valid, dist_ok, "distance above table range")
  `BRL_ASSERT_SAME(a_seen_first, out_valid, seen_ok, "status flag without seen flag")
  `BRL_ASSERT_SAME(a_ready_wrap, out_valid && out_report_ready, wrap_any, "ready without wrap")

endmodule

bind beacon_rssi_line_ranger brl_checker u_brl_checker (.*);
